/* hdl/bpd_pkg.sv */
package bpd_pkg;

    // field widths of one input word and one result word
    localparam int POS_W  = 20;
    localparam int WGT_W  = 16;
    localparam int IDX_W  = 8;
    localparam int FUNC_W = 2;
    localparam int ACC_W  = 48;

    // function codes carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_DEPOSIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FITS_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT  = 1'b1;

    // accumulator saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEPOSIT,
        ST_DRAIN,
        ST_READ
    } state_t;

    // occupancy of the update pipeline stages that still hold a pending write
    typedef struct packed {
        logic b_busy;
        logic c_busy;
    } pipe_status_t;

endpackage

/* hdl/bpd_pixel_ram.sv */
module bpd_pixel_ram #(
    parameter int AW = 16,
    parameter int DW = 48
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bpd_axis.sv */
module bpd_axis #(
    parameter int FRAC_BITS = 8,
    parameter int N         = 256
) (
    input  logic signed [bpd_pkg::POS_W-1:0] pos,
    input  logic                             fits,
    input  logic                             sel,
    output logic [$clog2(N)-1:0]             idx,
    output logic [FRAC_BITS:0]               share,
    output logic                             ok
);

    localparam int DW     = bpd_pkg::POS_W + 1;
    localparam int IW     = $clog2(N);
    localparam int HALF_I = 1 << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic signed [DW-1:0] d;
    logic signed [DW-1:0] base;
    logic signed [DW:0]   cand;
    logic [FRAC_BITS-1:0] frac;

    // offset from the centre of the lower neighbour
    assign d    = DW'(pos) - (fits ? DW'(0) : DW'(HALF_I));
    assign frac = d[FRAC_BITS-1:0];
    assign base = d >>> FRAC_BITS;
    assign cand = (DW+1)'(base) + (DW+1)'(sel);

    // lower neighbour gets 1 - frac, upper neighbour gets frac
    assign share = sel ? {1'b0, frac} : (ONE - {1'b0, frac});
    assign ok    = !cand[DW] && (cand[DW-1:0] < DW'(N)) && (share != '0);
    assign idx   = cand[IW-1:0];

endmodule

/* hdl/bpd_update.sv */
module bpd_update #(
    parameter int AW        = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               a_valid,
    input  logic [AW-1:0]                      a_addr,
    input  logic [2*FRAC_BITS+1:0]             a_xy,
    input  logic signed [bpd_pkg::WGT_W:0]     weight,
    input  logic [bpd_pkg::ACC_W-1:0]          rd_data,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic [bpd_pkg::ACC_W-1:0]          wr_data,
    output bpd_pkg::pipe_status_t              status
);

    localparam int ACC_W   = bpd_pkg::ACC_W;
    localparam int XYW     = 2 * FRAC_BITS + 2;
    localparam int PW      = XYW + bpd_pkg::WGT_W + 2;
    localparam int RESCALE = 2 * FRAC_BITS + 8 - 24;

    // stage b: memory data arrives, weight times share product
    logic                    vb_reg;
    logic [AW-1:0]           addr_b_reg;
    logic [XYW-1:0]          xy_b_reg;
    // stage c: rescale the product
    logic                    vc_reg;
    logic [AW-1:0]           addr_c_reg;
    logic signed [PW-1:0]    prod_c_reg;
    logic [ACC_W-1:0]        data_c_reg;
    // stage d: saturating add and write back
    logic                    vd_reg;
    logic [AW-1:0]           addr_d_reg;
    logic signed [ACC_W-1:0] contrib_d_reg;
    logic [ACC_W-1:0]        data_d_reg;

    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] contrib;
    logic signed [ACC_W:0]   sum;

    assign prod = weight * $signed({1'b0, xy_b_reg});

    generate
        if (RESCALE > 0) begin : g_round
            logic signed [PW:0] rnd;
            // round to nearest, ties towards plus infinity
            assign rnd     = (PW+1)'(prod_c_reg) + (PW+1)'(1 << (RESCALE - 1));
            assign contrib = ACC_W'(rnd >>> RESCALE);
        end else if (RESCALE < 0) begin : g_widen
            assign contrib = ACC_W'(prod_c_reg) <<< (-RESCALE);
        end else begin : g_plain
            assign contrib = ACC_W'(prod_c_reg);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            vb_reg <= a_valid;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
        addr_b_reg    <= a_addr;
        xy_b_reg      <= a_xy;
        addr_c_reg    <= addr_b_reg;
        prod_c_reg    <= prod;
        data_c_reg    <= rd_data;
        addr_d_reg    <= addr_c_reg;
        contrib_d_reg <= contrib;
        data_d_reg    <= data_c_reg;
    end

    assign sum = (ACC_W+1)'($signed(data_d_reg)) + (ACC_W+1)'(contrib_d_reg);

    always_comb begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            wr_data = sum[ACC_W] ? bpd_pkg::ACC_MIN : bpd_pkg::ACC_MAX;
        end else begin
            wr_data = sum[ACC_W-1:0];
        end
    end

    assign wr_en         = vd_reg;
    assign wr_addr       = addr_d_reg;
    assign status.b_busy = vb_reg;
    assign status.c_busy = vc_reg;

endmodule

/* hdl/bilinear_point_deposit.sv */
// bilinear point deposit: an image of COLS x ROWS signed 48-bit accumulators
// (24 fraction bits) held in one synchronous single-read, single-write memory.
// input words arrive on the s_ channel; s_tuser selects deposit, read or clear.
// a deposit spreads the weight onto up to four neighbouring pixels with
// bilinear shares; each pixel is read, added to with saturation and written
// back through a four-stage update pipeline. the four pixels are issued on
// consecutive cycles and the pipeline drains before the next word is accepted.
// a read returns one pixel on the m_ channel from the memory read register,
// held in an output register; a read of a pixel outside the image returns 0.
// a clear walks the whole memory one entry a cycle: 2**(clog2(COLS) +
// clog2(ROWS)) entries, 65536 for 256 x 256. the same walk runs after reset,
// during which s_tready stays low; configuration writes are taken at any time.
// while m_tready is low a finished read word waits in the output register and
// further words are still accepted; only a second read waits for the slot.
// the user writes fits_mode and subtract through the cfg_ port only while idle; not enforced.
module bilinear_point_deposit #(
    parameter int COLS      = 256,
    parameter int ROWS      = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [71:0]                        s_tdata,  // x_pos, y_pos, weight, read_col, read_row
    input  logic [bpd_pkg::FUNC_W-1:0]         s_tuser,  // func
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bpd_pkg::ACC_W-1:0]          m_tdata,  // pixel_value
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                               cfg_wdata
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = CW + RW;
    localparam int XYW   = 2 * FRAC_BITS + 2;
    localparam int CMP_W = 16;
    localparam int ACC_W = bpd_pkg::ACC_W;
    localparam int WGT_W = bpd_pkg::WGT_W;

    // unpacked input fields
    logic signed [bpd_pkg::POS_W-1:0] s_x_pos;
    logic signed [bpd_pkg::POS_W-1:0] s_y_pos;
    logic signed [WGT_W-1:0]          s_weight;
    logic [bpd_pkg::IDX_W-1:0]        s_read_col;
    logic [bpd_pkg::IDX_W-1:0]        s_read_row;

    assign s_x_pos    = s_tdata[19:0];
    assign s_y_pos    = s_tdata[39:20];
    assign s_weight   = s_tdata[55:40];
    assign s_read_col = s_tdata[63:56];
    assign s_read_row = s_tdata[71:64];

    bpd_pkg::state_t st_reg, st_next;

    logic                             fits_reg, sub_reg;
    logic [AW-1:0]                    clr_reg;
    logic [1:0]                       k_reg;
    logic signed [bpd_pkg::POS_W-1:0] x_reg, y_reg;
    logic signed [WGT_W:0]            w_reg;
    logic                             oob_reg;
    logic                             m_tvalid_reg;
    logic [ACC_W-1:0]                 m_tdata_reg;

    logic accept;
    logic rd_in_bounds;
    logic out_free;

    // neighbour selection for the pixel being issued
    logic [CW-1:0]        col_idx;
    logic [RW-1:0]        row_idx;
    logic [FRAC_BITS:0]   xs, ys;
    logic                 x_ok, y_ok;
    logic                 a_valid;
    logic [XYW-1:0]       a_xy;

    // memory ports
    logic             ram_wr_en, upd_wr_en;
    logic [AW-1:0]    ram_wr_addr, upd_wr_addr;
    logic [ACC_W-1:0] ram_wr_data, upd_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [ACC_W-1:0] ram_rd_data;

    bpd_pkg::pipe_status_t upd_status;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_in_bounds = (CMP_W'(s_read_col) < CMP_W'(COLS))
                       && (CMP_W'(s_read_row) < CMP_W'(ROWS));

    bpd_axis #(.FRAC_BITS(FRAC_BITS), .N(COLS)) u_axis_x (
        .pos   (x_reg),
        .fits  (fits_reg),
        .sel   (k_reg[1]),
        .idx   (col_idx),
        .share (xs),
        .ok    (x_ok)
    );

    bpd_axis #(.FRAC_BITS(FRAC_BITS), .N(ROWS)) u_axis_y (
        .pos   (y_reg),
        .fits  (fits_reg),
        .sel   (k_reg[0]),
        .idx   (row_idx),
        .share (ys),
        .ok    (y_ok)
    );

    // stage a: issue the pixel read and form the combined share
    assign a_valid = (st_reg == bpd_pkg::ST_DEPOSIT) && x_ok && y_ok;
    assign a_xy    = XYW'(xs) * XYW'(ys);

    bpd_update #(.AW(AW), .FRAC_BITS(FRAC_BITS)) u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_valid (a_valid),
        .a_addr  ({row_idx, col_idx}),
        .a_xy    (a_xy),
        .weight  (w_reg),
        .rd_data (ram_rd_data),
        .wr_en   (upd_wr_en),
        .wr_addr (upd_wr_addr),
        .wr_data (upd_wr_data),
        .status  (upd_status)
    );

    // the clear walk owns the write port, otherwise the update pipeline
    always_comb begin
        if (st_reg == bpd_pkg::ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = upd_wr_en;
            ram_wr_addr = upd_wr_addr;
            ram_wr_data = upd_wr_data;
        end
    end

    always_comb begin
        if (st_reg == bpd_pkg::ST_DEPOSIT) begin
            ram_rd_en   = a_valid;
            ram_rd_addr = {row_idx, col_idx};
        end else begin
            ram_rd_en   = accept && (s_tuser == bpd_pkg::FUNC_READ);
            ram_rd_addr = {RW'(s_read_row), CW'(s_read_col)};
        end
    end

    bpd_pixel_ram #(.AW(AW), .DW(ACC_W)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // sequencer
    always_comb begin
        st_next  = st_reg;
        s_tready = 1'b0;
        case (st_reg)
            bpd_pkg::ST_CLEAR: begin
                if (clr_reg == '1) begin
                    st_next = bpd_pkg::ST_IDLE;
                end
            end
            bpd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_tuser)
                        bpd_pkg::FUNC_DEPOSIT: st_next = bpd_pkg::ST_DEPOSIT;
                        bpd_pkg::FUNC_READ:    st_next = bpd_pkg::ST_READ;
                        bpd_pkg::FUNC_CLEAR:   st_next = bpd_pkg::ST_CLEAR;
                        default:               st_next = bpd_pkg::ST_IDLE;
                    endcase
                end
            end
            bpd_pkg::ST_DEPOSIT: begin
                if (k_reg == 2'd3) begin
                    st_next = bpd_pkg::ST_DRAIN;
                end
            end
            bpd_pkg::ST_DRAIN: begin
                // the last write may still be in stage d: it lands this edge
                if (!upd_status.b_busy && !upd_status.c_busy) begin
                    st_next = bpd_pkg::ST_IDLE;
                end
            end
            bpd_pkg::ST_READ: begin
                if (out_free) begin
                    st_next = bpd_pkg::ST_IDLE;
                end
            end
            default: st_next = bpd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= bpd_pkg::ST_CLEAR;
            clr_reg      <= '0;
            k_reg        <= '0;
            fits_reg     <= 1'b1;
            sub_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    bpd_pkg::CFG_FITS_MODE: fits_reg <= cfg_wdata;
                    bpd_pkg::CFG_SUBTRACT:  sub_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            if (st_reg == bpd_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (st_reg == bpd_pkg::ST_DEPOSIT) begin
                k_reg <= k_reg + 1'b1;
            end else begin
                k_reg <= '0;
            end

            if (st_reg == bpd_pkg::ST_READ && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        // item payload
        if (accept) begin
            x_reg   <= s_x_pos;
            y_reg   <= s_y_pos;
            w_reg   <= sub_reg ? -(WGT_W+1)'(s_weight) : (WGT_W+1)'(s_weight);
            oob_reg <= !rd_in_bounds;
        end
        if (st_reg == bpd_pkg::ST_READ && out_free) begin
            m_tdata_reg <= oob_reg ? '0 : ram_rd_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a pixel is never read while its updated value is being written back
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("read and write of the same pixel in one cycle");

    // new words are only taken once no deposit write is left in flight
    a_accept_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!upd_status.b_busy && !upd_status.c_busy))
        else $error("word accepted while the update pipeline is busy");

    // a result word only appears after a read has been served
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(st_reg == bpd_pkg::ST_READ))
        else $error("result word raised outside a read");

    // the update pipeline only runs during a deposit or its drain
    a_pipe_in_deposit: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_status.b_busy |-> (st_reg == bpd_pkg::ST_DEPOSIT || st_reg == bpd_pkg::ST_DRAIN))
        else $error("update pipeline busy outside a deposit");

endmodule
